>>> design/jobs_pkg.sv
// Package for the JSON object byte serializer: opcodes, character codes,
// payload structs and the run descriptor that the front hands to the back.
// No dependencies.
package jobs_pkg;

   localparam int unsigned RUN_MAX     = 7;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned RCNT_W      = $clog2(RUN_MAX + 1);

   // token opcodes
   localparam logic [2:0] OP_BEGIN_OBJ  = 3'd0;
   localparam logic [2:0] OP_BEGIN_PAIR = 3'd1;
   localparam logic [2:0] OP_KEY_BYTE   = 3'd2;
   localparam logic [2:0] OP_KEY_END    = 3'd3;
   localparam logic [2:0] OP_VALUE_BYTE = 3'd4;
   localparam logic [2:0] OP_VALUE_END  = 3'd5;
   localparam logic [2:0] OP_FINISH     = 3'd6;

   // characters
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_U      = 8'h75;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data_byte;
      logic       quoted;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   // one token's worth of output bytes, oldest in slot 0
   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;
      logic [RCNT_W-1:0]       count;
   } desc_type;

endpackage

>>> design/jobs_front.sv
// Token front end: holds the layout register and object state, turns each
// accepted token into a run descriptor of up to seven bytes.
// Depends on jobs_pkg.
module jobs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic              csr_write_data,
   input  logic              req_push,
   input  jobs_pkg::req_type req_payload,
   input  logic              q_full,
   output logic              q_push,
   output jobs_pkg::desc_type q_desc,
   output logic              req_full
);

   logic indented_ff, indented_in;
   logic has_entries_ff, has_entries_in;
   logic value_quoted_ff, value_quoted_in;
   logic accept;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] code;
      if (nib < 4'd10) begin
         code = 8'h30 + {4'd0, nib};
      end else begin
         code = 8'h57 + {4'd0, nib};
      end
      return code;
   endfunction

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      logic [jobs_pkg::RCNT_W-1:0] n;
      logic [7:0]                  sc;
      logic [7:0]                  c;
      n  = '0;
      sc = '0;
      c  = req_payload.data_byte;
      q_desc          = '0;
      has_entries_in  = has_entries_ff;
      value_quoted_in = value_quoted_ff;
      unique case (req_payload.opcode) inside
         jobs_pkg::OP_BEGIN_OBJ: begin
            q_desc.bytes[n] = jobs_pkg::CH_LBRACE; n = n + 3'd1;
            if (indented_ff) begin
               q_desc.bytes[n] = jobs_pkg::CH_LF; n = n + 3'd1;
            end
            has_entries_in = 1'b0;
         end
         jobs_pkg::OP_BEGIN_PAIR: begin
            if (has_entries_ff) begin
               q_desc.bytes[n] = jobs_pkg::CH_COMMA; n = n + 3'd1;
               q_desc.bytes[n] = indented_ff ? jobs_pkg::CH_LF : jobs_pkg::CH_SPACE;
               n = n + 3'd1;
            end
            if (indented_ff) begin
               for (int i = 0; i < 4; i++) begin
                  q_desc.bytes[n] = jobs_pkg::CH_SPACE; n = n + 3'd1;
               end
            end
            q_desc.bytes[n] = jobs_pkg::CH_QUOTE; n = n + 3'd1;
         end
         jobs_pkg::OP_KEY_BYTE, jobs_pkg::OP_VALUE_BYTE: begin
            unique case (c)
               8'h08:              sc = 8'h62; // b
               8'h0c:              sc = 8'h66; // f
               8'h0a:              sc = 8'h6e; // n
               8'h0d:              sc = 8'h72; // r
               8'h09:              sc = 8'h74; // t
               jobs_pkg::CH_BSLASH: sc = jobs_pkg::CH_BSLASH;
               jobs_pkg::CH_QUOTE:  sc = jobs_pkg::CH_QUOTE;
               default:            sc = '0;
            endcase
            if (sc != 8'h00) begin
               q_desc.bytes[n] = jobs_pkg::CH_BSLASH; n = n + 3'd1;
               q_desc.bytes[n] = sc;                  n = n + 3'd1;
            end else if (c < 8'h20) begin
               // control byte, including zero: \u00XX
               q_desc.bytes[n] = jobs_pkg::CH_BSLASH; n = n + 3'd1;
               q_desc.bytes[n] = jobs_pkg::CH_U;      n = n + 3'd1;
               q_desc.bytes[n] = jobs_pkg::CH_ZERO;   n = n + 3'd1;
               q_desc.bytes[n] = jobs_pkg::CH_ZERO;   n = n + 3'd1;
               q_desc.bytes[n] = hex_char(c[7:4]);    n = n + 3'd1;
               q_desc.bytes[n] = hex_char(c[3:0]);    n = n + 3'd1;
            end else begin
               q_desc.bytes[n] = c; n = n + 3'd1;
            end
         end
         jobs_pkg::OP_KEY_END: begin
            q_desc.bytes[n] = jobs_pkg::CH_QUOTE; n = n + 3'd1;
            q_desc.bytes[n] = jobs_pkg::CH_COLON; n = n + 3'd1;
            q_desc.bytes[n] = jobs_pkg::CH_SPACE; n = n + 3'd1;
            if (req_payload.quoted) begin
               q_desc.bytes[n] = jobs_pkg::CH_QUOTE; n = n + 3'd1;
            end
            value_quoted_in = req_payload.quoted;
         end
         jobs_pkg::OP_VALUE_END: begin
            if (value_quoted_ff) begin
               q_desc.bytes[n] = jobs_pkg::CH_QUOTE; n = n + 3'd1;
            end
            has_entries_in = 1'b1;
         end
         jobs_pkg::OP_FINISH: begin
            q_desc.bytes[n] = indented_ff ? jobs_pkg::CH_LF : jobs_pkg::CH_SPACE;
            n = n + 3'd1;
            q_desc.bytes[n] = jobs_pkg::CH_RBRACE; n = n + 3'd1;
         end
         default: begin
            // unused opcode: no bytes, no state change
         end
      endcase
      q_desc.count = n;
   end

   // tokens that produce nothing never reach the queue
   assign q_push = accept && (q_desc.count != '0);

   assign indented_in = csr_write_en ? csr_write_data : indented_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         indented_ff     <= 1'b0;
         has_entries_ff  <= 1'b0;
         value_quoted_ff <= 1'b0;
      end else begin
         indented_ff <= indented_in;
         if (accept) begin
            has_entries_ff  <= has_entries_in;
            value_quoted_ff <= value_quoted_in;
         end
      end
   end

endmodule

>>> design/jobs_queue.sv
// Short descriptor queue between front and back; push and pop may coincide.
// Depends on jobs_pkg.
module jobs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jobs_pkg::desc_type push_desc,
   input  logic               pop,
   output jobs_pkg::desc_type head_desc,
   output logic               full,
   output logic               empty
);

   jobs_pkg::desc_type                entry_ff [jobs_pkg::QUEUE_DEPTH];
   logic [jobs_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [jobs_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [jobs_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign full      = (count_ff == jobs_pkg::QCNT_W'(jobs_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= jobs_pkg::QCNT_W'(jobs_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

>>> design/jobs_back.sv
// Byte sequencer: walks the head descriptor one byte per transfer and
// releases it after its last byte. Depends on jobs_pkg.
module jobs_back (
   input  logic               clock,
   input  logic               reset,
   input  jobs_pkg::desc_type head_desc,
   input  logic               q_empty,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output jobs_pkg::rsp_type  rsp_payload
);

   logic [jobs_pkg::RCNT_W-1:0] index_ff, index_in;
   logic                        is_last;
   logic                        xfer;

   assign is_last   = (index_ff == head_desc.count - 1'b1);
   assign rsp_empty = q_empty;
   assign xfer      = rsp_pop && !q_empty;
   assign q_pop     = xfer && is_last;

   assign rsp_payload.out_byte    = head_desc.bytes[index_ff];
   assign rsp_payload.last_of_run = is_last;

   always_comb begin
      index_in = index_ff;
      if (xfer) begin
         index_in = is_last ? '0 : index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else begin
         index_ff <= index_in;
      end
   end

`ifndef ASSERT_OFF
   a_index_in_run: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (index_ff < head_desc.count))
      else $error("byte index past end of run");
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> (index_ff == '0))
      else $error("byte index not rewound while queue empty");
`endif

endmodule

>>> design/json_object_byte_serializer_top.sv
// Top level of the JSON object byte serializer: front end, descriptor queue
// and byte sequencer. Depends on jobs_pkg, jobs_front, jobs_queue, jobs_back.
//
//  channel | ports                              | direction | transfer when
//  --------+------------------------------------+-----------+---------------------
//  request | req_push, req_full, req_payload    | in        | req_push && !req_full
//  result  | rsp_pop, rsp_empty, rsp_payload    | out       | rsp_pop && !rsp_empty
//  config  | csr_write_en, csr_write_data       | in        | csr_write_en
//
// One token is taken per cycle while the descriptor queue (four runs) has room;
// each token is classified and escaped in that same cycle.
// The back end gives one byte per cycle while popped, so a token of N bytes
// (1 to 7) takes N pops; sustained rate is bounded by that byte sequencer.
// First byte of a run can be popped the cycle after its token is taken.
// Reset is synchronous and clears layout, object state and the queue.
// A stalled result side fills the queue and then raises req_full.
module json_object_byte_serializer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic              csr_write_data,
   input  logic              req_push,
   input  jobs_pkg::req_type req_payload,
   output logic              req_full,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output jobs_pkg::rsp_type rsp_payload
);

   jobs_pkg::desc_type push_desc;
   jobs_pkg::desc_type head_desc;
   logic               q_push, q_pop, q_full, q_empty;

   // classify tokens and build runs
   jobs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_push       (req_push),
      .req_payload    (req_payload),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_desc         (push_desc),
      .req_full       (req_full)
   );

   // decouples the token side from byte output
   jobs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   // emit runs byte by byte
   jobs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_desc   (head_desc),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> bench/json_text_scoreboard_pkg.sv
// Scoreboard for the JSON object byte serializer bench: predicts the bytes
// each token adds to the JSON text and checks popped bytes against them.
// Depends on jobs_pkg.
package json_text_scoreboard_pkg;
   import jobs_pkg::*;

   // unused opcode, plus control characters with short escapes
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_FF     = 8'h0c;
   localparam logic [7:0] CH_CR     = 8'h0d;

   class json_text_scoreboard;
      rsp_type     expected_bytes[$];
      bit          indented;
      bit          has_entries;
      bit          value_quoted;
      int unsigned failures;

      function new();
         indented     = 1'b0;
         has_entries  = 1'b0;
         value_quoted = 1'b0;
         failures     = 0;
      endfunction

      function void set_layout(bit mode);
         indented = mode;
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction

      function logic [7:0] hex_char(logic [3:0] nibble);
         return (nibble < 4'd10) ? CH_ZERO + 8'(nibble) : 8'h61 + 8'(nibble - 4'd10);
      endfunction

      // one accepted token: append its run of bytes to the expected stream
      function void note_token(req_type token);
         logic [7:0] run[$];
         logic [7:0] short_code;
         rsp_type    item;
         case (token.opcode)
            OP_BEGIN_OBJ: begin
               run.push_back(CH_LBRACE);
               if (indented) run.push_back(CH_LF);
               has_entries = 1'b0;
            end
            OP_BEGIN_PAIR: begin
               if (has_entries) begin
                  run.push_back(CH_COMMA);
                  run.push_back(indented ? CH_LF : CH_SPACE);
               end
               if (indented) repeat (4) run.push_back(CH_SPACE);
               run.push_back(CH_QUOTE);
            end
            OP_KEY_BYTE, OP_VALUE_BYTE: begin
               case (token.data_byte)
                  CH_BS:     short_code = "b";
                  CH_FF:     short_code = "f";
                  CH_LF:     short_code = "n";
                  CH_CR:     short_code = "r";
                  CH_TAB:    short_code = "t";
                  CH_BSLASH: short_code = CH_BSLASH;
                  CH_QUOTE:  short_code = CH_QUOTE;
                  default:   short_code = 8'h00;
               endcase
               if (short_code != 8'h00) begin
                  run.push_back(CH_BSLASH);
                  run.push_back(short_code);
               end else if (token.data_byte < CH_SPACE) begin
                  run.push_back(CH_BSLASH);
                  run.push_back(CH_U);
                  run.push_back(CH_ZERO);
                  run.push_back(CH_ZERO);
                  run.push_back(hex_char(token.data_byte[7:4]));
                  run.push_back(hex_char(token.data_byte[3:0]));
               end else begin
                  run.push_back(token.data_byte);
               end
            end
            OP_KEY_END: begin
               run.push_back(CH_QUOTE);
               run.push_back(CH_COLON);
               run.push_back(CH_SPACE);
               if (token.quoted) run.push_back(CH_QUOTE);
               value_quoted = token.quoted;
            end
            OP_VALUE_END: begin
               if (value_quoted) run.push_back(CH_QUOTE);
               has_entries = 1'b1;
            end
            OP_FINISH: begin
               run.push_back(indented ? CH_LF : CH_SPACE);
               run.push_back(CH_RBRACE);
            end
            default: ;
         endcase
         foreach (run[i]) begin
            item.out_byte    = run[i];
            item.last_of_run = (i == run.size() - 1);
            expected_bytes.push_back(item);
         end
      endfunction

      // one popped byte against the oldest expectation
      function void check_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            $error("out_byte: nothing expected, got %h", got.out_byte);
            failures++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            failures++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
            failures++;
         end
      endfunction
   endclass

endpackage

>>> bench/tb_top.sv
// Top-level bench for the JSON object byte serializer: drives tokens and
// layout writes, pops bytes with random stalls, checks via the scoreboard.
// Depends on jobs_pkg, json_text_scoreboard_pkg, json_object_byte_serializer_top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jobs_pkg::*;
   import json_text_scoreboard_pkg::*;

   localparam int unsigned TOKEN_TARGET  = 320;  // tokens that produce work
   localparam int unsigned QUIET_TAIL    = 60;   // last tokens go without idling
   localparam int unsigned PHASE_TOKENS  = 50;   // tokens per layout setting
   localparam int unsigned SETTLE_CYCLES = 8;    // covers a token with no bytes
   localparam int unsigned STALL_LIMIT   = 1000; // cycles without any transfer

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_write_en;
   logic    csr_write_data;
   logic    req_push;
   req_type req_payload;
   logic    req_full;
   logic    rsp_pop;
   logic    rsp_empty;
   rsp_type rsp_payload;

   json_text_scoreboard sb = new();

   int unsigned tokens_sent = 0;
   int unsigned stall_cycles = 0;
   int unsigned phase_no = 0;
   bit          quiet_tail = 1'b0;
   bit          broken_object = 1'b0;

   // directed probes: every escape class for keys and values
   logic [7:0] key_probe[3]   = '{8'h00, CH_QUOTE, CH_BSLASH};
   logic [7:0] value_probe[8] = '{CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB, 8'h1f, 8'hff, CH_SPACE};
   logic [7:0] odd_bytes[6]   = '{CH_QUOTE, CH_BSLASH, 8'h7f, 8'h80, 8'hff, CH_SPACE};

   json_object_byte_serializer_top DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_push       (req_push),
      .req_payload    (req_payload),
      .req_full       (req_full),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_payload    (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Byte mix: control characters, characters needing a backslash, high
   // bytes and plain random ones.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(0, 31));
         1:       return odd_bytes[$urandom_range(0, 5)];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Broken objects lose about a quarter of their tokens.
   function automatic bit keep_token();
      return !broken_object || $urandom_range(0, 3) != 0;
   endfunction

   // Push one token and hold until the transfer; the token goes to the
   // scoreboard at the accepting edge. req_full is read right after the edge,
   // so it is the value the block saw. A random gap may follow.
   task automatic send(input logic [2:0] op, input logic [7:0] data, input logic q);
      req_type token;
      token.opcode    = op;
      token.data_byte = data;
      token.quoted    = q;
      req_payload <= token;
      req_push    <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note_token(token);
      if (op != OP_UNUSED) tokens_sent++;
      quiet_tail = tokens_sent + QUIET_TAIL >= TOKEN_TARGET;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_push    <= 1'b0;
         req_payload <= req_type'($urandom);
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Sender holds off until every expected byte is out, then lets the block
   // settle, since a bare value end leaves nothing to wait for.
   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_layout(input bit mode);
      csr_write_en   <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.set_layout(mode);
   endtask

   // A flat object with random pairs; now and then broken by dropped tokens.
   task automatic send_object();
      int unsigned pairs;
      int unsigned key_len;
      int unsigned value_len;
      logic        q;
      broken_object = $urandom_range(0, 5) == 0;
      pairs = $urandom_range(0, 4);
      if (keep_token()) send(OP_BEGIN_OBJ, 8'($urandom), 1'($urandom));
      repeat (pairs) begin
         key_len   = $urandom_range(0, 4);
         value_len = $urandom_range(0, 5);
         q         = 1'($urandom);
         if (keep_token()) send(OP_BEGIN_PAIR, 8'($urandom), 1'($urandom));
         repeat (key_len)
            if (keep_token()) send(OP_KEY_BYTE, pick_byte(), 1'($urandom));
         if (keep_token()) send(OP_KEY_END, 8'($urandom), q);
         repeat (value_len)
            if (keep_token()) send(OP_VALUE_BYTE, pick_byte(), 1'($urandom));
         if (keep_token()) send(OP_VALUE_END, 8'($urandom), 1'($urandom));
      end
      if (keep_token()) send(OP_FINISH, 8'($urandom), 1'($urandom));
   endtask

   // Result side: pop, with stall bursts except in the quiet tail.
   initial begin
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
      end
   end

   // Every popped byte is checked at the edge that transfers it.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_byte(rsp_payload);
   end

   // Watchdog: a long run of cycles with no transfer at all means a hang.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = 1'b0;
      req_push       = 1'b0;
      req_payload    = '0;
      rsp_pop        = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, compact layout from reset. Tokens out of order first:
      // a bare value end gives no bytes but marks entries, so the next pair
      // opens with a comma even before any object was begun.
      send(OP_VALUE_END, 8'hff, 1'b1);
      send(OP_BEGIN_PAIR, 8'h00, 1'b1);
      send(OP_BEGIN_OBJ, 8'h5a, 1'b1);
      send(OP_BEGIN_PAIR, 8'hff, 1'b0);
      foreach (key_probe[i]) send(OP_KEY_BYTE, key_probe[i], 1'($urandom));
      send(OP_KEY_END, 8'($urandom), 1'b1);
      foreach (value_probe[i]) send(OP_VALUE_BYTE, value_probe[i], 1'($urandom));
      send(OP_VALUE_END, 8'($urandom), 1'b0);
      send(OP_BEGIN_PAIR, 8'($urandom), 1'b1);
      send(OP_KEY_BYTE, 8'h7f, 1'b1);
      send(OP_KEY_END, 8'($urandom), 1'b0);
      send(OP_VALUE_BYTE, 8'h10, 1'b0);
      send(OP_VALUE_END, 8'($urandom), 1'b1);  // bare value: no bytes
      send(OP_UNUSED, 8'hff, 1'b1);            // ignored entirely
      send(OP_FINISH, 8'($urandom), 1'($urandom));

      // Random phases: indented first, then compact, then either. Each
      // layout change waits for the block to run dry.
      while (tokens_sent < TOKEN_TARGET) begin
         drain();
         write_layout(phase_no == 0 ? 1'b1 : phase_no == 1 ? 1'b0 : 1'($urandom));
         phase_no++;
         for (int unsigned start = tokens_sent;
              tokens_sent - start < PHASE_TOKENS && tokens_sent < TOKEN_TARGET;) begin
            if ($urandom_range(0, 9) == 0)
               send($urandom_range(0, 1) ? OP_UNUSED : 3'($urandom_range(0, 6)),
                    8'($urandom), 1'($urandom));
            else
               send_object();
         end
      end

      drain();
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
